FILE: sv/fmk_pkg.sv
// Shared types, codes and the sequencing step function of the Morse FSK keyer.
package fmk_pkg;

	// Item function codes.
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_KEY   = 2'd2;

	// Symbol codes.
	localparam logic [1:0] SYM_DOT  = 2'd0;
	localparam logic [1:0] SYM_DASH = 2'd1;
	localparam logic [1:0] SYM_PRE  = 2'd2;

	// Sequencer phase codes.
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_RAMP_UP = 3'd1;
	localparam logic [2:0] PH_HOLD    = 3'd2;
	localparam logic [2:0] PH_RAMP_DN = 3'd3;
	localparam logic [2:0] PH_GAP     = 3'd4;
	localparam logic [2:0] PH_PRE_GAP = 3'd5;

	// Register bus geometry and register indexes.
	localparam int          APB_AW       = 5;
	localparam logic [2:0] REG_HIGH      = 3'd0;
	localparam logic [2:0] REG_LOW       = 3'd1;
	localparam logic [2:0] REG_RAMP_UP   = 3'd2;
	localparam logic [2:0] REG_RAMP_DN   = 3'd3;
	localparam logic [2:0] REG_DOT_HOLD  = 3'd4;
	localparam logic [2:0] REG_DASH_HOLD = 3'd5;
	localparam logic [2:0] REG_GAP       = 3'd6;

	// Register reset values.
	localparam logic [7:0]  HIGH_RESET      = 8'd200;
	localparam logic [7:0]  LOW_RESET       = 8'd100;
	localparam logic [15:0] RAMP_UP_RESET   = 16'd50;
	localparam logic [15:0] RAMP_DN_RESET   = 16'd0;
	localparam logic [15:0] DOT_HOLD_RESET  = 16'd3000;
	localparam logic [15:0] DASH_HOLD_RESET = 16'd6000;
	localparam logic [15:0] GAP_RESET       = 16'd3000;

	// Duty level after reset.
	localparam logic [7:0] DUTY_RESET = 8'd128;

	// Number of zero-time sequencing steps one item may need.
	localparam int ADV_STEPS = 4;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] symbol;
		logic       key_level;
	} fmk_item_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       key_on;
		logic       busy_res;
		logic       rejected;
	} fmk_result_t;

	typedef struct packed {
		logic [7:0]  high_level;
		logic [7:0]  low_level;
		logic [15:0] ramp_up_ticks;
		logic [15:0] ramp_down_ticks;
		logic [15:0] dot_hold_ticks;
		logic [15:0] dash_hold_ticks;
		logic [15:0] gap_ticks;
	} fmk_cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  duty_level;
		logic [15:0] wait_count;
		logic        key_state;
		logic        is_dash;
	} fmk_state_t;

	// One zero-time action of the sequencer; leaves the state alone while a wait
	// is pending or the keyer is idle.
	function automatic fmk_state_t fmk_adv_step(fmk_state_t s, fmk_cfg_t c);
		fmk_state_t r;
		r = s;
		if (s.wait_count == 16'd0 && s.phase != PH_IDLE) begin
			unique case (s.phase)
				PH_RAMP_UP: begin
					if (s.duty_level == c.high_level || c.ramp_up_ticks == 16'd0) begin
						r.duty_level = c.high_level;
						r.phase      = PH_HOLD;
						r.wait_count = s.is_dash ? c.dash_hold_ticks : c.dot_hold_ticks;
					end else begin
						r.duty_level = (s.duty_level < c.high_level) ?
							s.duty_level + 8'd1 : s.duty_level - 8'd1;
						r.wait_count = c.ramp_up_ticks;
					end
				end
				PH_HOLD: begin
					r.key_state = 1'b0;
					r.phase     = PH_RAMP_DN;
				end
				PH_RAMP_DN: begin
					if (s.duty_level == c.low_level || c.ramp_down_ticks == 16'd0) begin
						r.duty_level = c.low_level;
						r.phase      = PH_GAP;
						r.wait_count = c.gap_ticks;
					end else begin
						r.duty_level = (s.duty_level < c.low_level) ?
							s.duty_level + 8'd1 : s.duty_level - 8'd1;
						r.wait_count = c.ramp_down_ticks;
					end
				end
				PH_GAP: begin
					r.key_state = 1'b1;
					r.phase     = PH_IDLE;
				end
				default: begin
					r.phase = PH_IDLE;
				end
			endcase
		end
		return r;
	endfunction

endpackage

FILE: sv/fsk_morse_symbol_keyer.sv
// Top level of the slow Morse FSK keyer: item register, engine and result register.
// The keyer takes one item per clock cycle when the result side keeps up; a
// transferred item waits in the item register, and its result goes to the result
// register when the engine processes it. The single pass through the sequencing
// logic of the engine applies a tick or command together with all of its
// zero-time actions (up to four). Timers advance only on tick items, never on
// clock cycles. The user must write registers through the APB-style port only
// while the keyer is quiet; the keyer itself does not enforce this.
module fsk_morse_symbol_keyer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  fmk_pkg::fmk_item_t         item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output fmk_pkg::fmk_result_t       result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fmk_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	fmk_pkg::fmk_cfg_t    cfg;
	fmk_pkg::fmk_item_t   item_s1;
	logic                 valid_s1;
	fmk_pkg::fmk_result_t res;
	fmk_pkg::fmk_result_t result_s2;
	logic                 valid_s2;
	logic                 go;
	logic                 load;

	// Stage one moves on when the result register is empty or being taken.
	assign go         = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !go;
	assign load       = item_valid && !item_stall;

	fmk_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fmk_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Item register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

FILE: sv/fmk_cfg_regs.sv
// Register file of the keyer behind its APB-style configuration port.
module fmk_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fmk_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output fmk_pkg::fmk_cfg_t          cfg
);

	fmk_pkg::fmk_cfg_t cfg_q;
	logic [2:0]        reg_idx;
	logic              wr_en;

	// Word index from the byte address; the access phase completes a write.
	assign reg_idx = paddr[fmk_pkg::APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_level      <= fmk_pkg::HIGH_RESET;
			cfg_q.low_level       <= fmk_pkg::LOW_RESET;
			cfg_q.ramp_up_ticks   <= fmk_pkg::RAMP_UP_RESET;
			cfg_q.ramp_down_ticks <= fmk_pkg::RAMP_DN_RESET;
			cfg_q.dot_hold_ticks  <= fmk_pkg::DOT_HOLD_RESET;
			cfg_q.dash_hold_ticks <= fmk_pkg::DASH_HOLD_RESET;
			cfg_q.gap_ticks       <= fmk_pkg::GAP_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				fmk_pkg::REG_HIGH:      cfg_q.high_level      <= pwdata[7:0];
				fmk_pkg::REG_LOW:       cfg_q.low_level       <= pwdata[7:0];
				fmk_pkg::REG_RAMP_UP:   cfg_q.ramp_up_ticks   <= pwdata[15:0];
				fmk_pkg::REG_RAMP_DN:   cfg_q.ramp_down_ticks <= pwdata[15:0];
				fmk_pkg::REG_DOT_HOLD:  cfg_q.dot_hold_ticks  <= pwdata[15:0];
				fmk_pkg::REG_DASH_HOLD: cfg_q.dash_hold_ticks <= pwdata[15:0];
				fmk_pkg::REG_GAP:       cfg_q.gap_ticks       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (reg_idx)
			fmk_pkg::REG_HIGH:      prdata = {24'd0, cfg_q.high_level};
			fmk_pkg::REG_LOW:       prdata = {24'd0, cfg_q.low_level};
			fmk_pkg::REG_RAMP_UP:   prdata = {16'd0, cfg_q.ramp_up_ticks};
			fmk_pkg::REG_RAMP_DN:   prdata = {16'd0, cfg_q.ramp_down_ticks};
			fmk_pkg::REG_DOT_HOLD:  prdata = {16'd0, cfg_q.dot_hold_ticks};
			fmk_pkg::REG_DASH_HOLD: prdata = {16'd0, cfg_q.dash_hold_ticks};
			fmk_pkg::REG_GAP:       prdata = {16'd0, cfg_q.gap_ticks};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

FILE: sv/fmk_engine.sv
// Keyer state and the single-pass logic that applies one item to it.
module fmk_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  fmk_pkg::fmk_item_t    item,
	input  fmk_pkg::fmk_cfg_t     cfg,
	output fmk_pkg::fmk_result_t  res
);

	fmk_pkg::fmk_state_t state_q;
	fmk_pkg::fmk_state_t cmd_st;
	fmk_pkg::fmk_state_t adv_st [fmk_pkg::ADV_STEPS+1];
	logic                busy;
	logic                rej;

	assign busy = (state_q.phase != fmk_pkg::PH_IDLE);

	// Apply the command or tick itself.
	always_comb begin
		cmd_st = state_q;
		rej    = 1'b0;
		case (item.func)
			fmk_pkg::FUNC_TICK: begin
				if (busy && state_q.wait_count != 16'd0) begin
					cmd_st.wait_count = state_q.wait_count - 16'd1;
				end
			end
			fmk_pkg::FUNC_START: begin
				if (busy) begin
					rej = 1'b1;
				end else if (item.symbol == fmk_pkg::SYM_DOT ||
					item.symbol == fmk_pkg::SYM_DASH) begin
					cmd_st.is_dash    = (item.symbol == fmk_pkg::SYM_DASH);
					cmd_st.phase      = fmk_pkg::PH_RAMP_UP;
					cmd_st.wait_count = 16'd0;
				end else if (item.symbol == fmk_pkg::SYM_PRE) begin
					cmd_st.duty_level = cfg.low_level;
					cmd_st.phase      = fmk_pkg::PH_PRE_GAP;
					cmd_st.wait_count = cfg.gap_ticks;
				end
			end
			fmk_pkg::FUNC_KEY: begin
				if (busy) begin
					rej = 1'b1;
				end else begin
					cmd_st.key_state = item.key_level;
				end
			end
			default: ;
		endcase
	end

	// Chain of zero-time sequencing actions; each is a no-op once a wait is
	// pending or the keyer has gone idle.
	always_comb begin
		adv_st[0] = cmd_st;
		for (int k = 0; k < fmk_pkg::ADV_STEPS; k++) begin
			adv_st[k+1] = fmk_pkg::fmk_adv_step(adv_st[k], cfg);
		end
	end

	// State update once per transferred item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= fmk_pkg::PH_IDLE;
			state_q.duty_level <= fmk_pkg::DUTY_RESET;
			state_q.wait_count <= 16'd0;
			state_q.key_state  <= 1'b0;
			state_q.is_dash    <= 1'b0;
		end else if (go) begin
			state_q <= adv_st[fmk_pkg::ADV_STEPS];
		end
	end

	// Result fields follow the state after the item.
	assign res.duty     = adv_st[fmk_pkg::ADV_STEPS].duty_level;
	assign res.key_on   = adv_st[fmk_pkg::ADV_STEPS].key_state;
	assign res.busy_res = (adv_st[fmk_pkg::ADV_STEPS].phase != fmk_pkg::PH_IDLE);
	assign res.rejected = rej;

	// A busy keyer always has a wait pending; an idle one never does.
	a_busy_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == fmk_pkg::PH_IDLE) == (state_q.wait_count == 16'd0))
		else $error("busy state and pending wait disagree");

	// The state moves only when an item is processed.
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(state_q))
		else $error("keyer state changed without an item");

	// A rejected command leaves the keyer busy.
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.rejected |-> res.busy_res)
		else $error("rejected command reported while idle");

endmodule

FILE: test/fsk_morse_symbol_keyer_test.sv
// Self-checking testbench of the slow Morse FSK keyer, checked against a predictor.
`timescale 1ns / 100ps

module fsk_morse_symbol_keyer_test;
	import fmk_pkg::*;

	// Codes the package leaves unnamed: the spare function and the spare symbol.
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [1:0] SYM_NONE  = 2'd3;

	// Idling modes.
	localparam int MODE_NONE     = 0;
	localparam int MODE_SENDER   = 1;
	localparam int MODE_RECEIVER = 2;
	localparam int MODE_BOTH     = 3;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 400;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	fmk_item_t           item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	fmk_result_t         result;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	fsk_morse_symbol_keyer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// Keyer settings as last written over the register port.
	logic [7:0]  cf_high, cf_low;
	logic [15:0] cf_ramp_up, cf_ramp_dn, cf_dot, cf_dash, cf_gap;

	// Predicted sequencer state.
	logic [2:0]  kp_phase;
	logic [7:0]  kp_duty;
	logic [15:0] kp_wait;
	logic        kp_key;
	logic        kp_dash;

	fmk_item_t   item_backlog[$];
	fmk_result_t keyer_outputs_due[$];
	int unsigned items_queued = 0;
	int unsigned outputs_matched = 0;
	int unsigned error_count = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned hold_left = 0;
	bit          hold_req = 1'b0;
	int unsigned quiet_cycles = 0;

	// One duty step toward the target; true once the duty has arrived.
	function automatic bit keyer_ramp(input logic [7:0] target, input logic [15:0] interval);
		if (kp_duty == target)
			return 1'b1;
		if (interval == 16'd0) begin
			kp_duty = target;
			return 1'b1;
		end
		if (kp_duty < target)
			kp_duty = kp_duty + 8'd1;
		else
			kp_duty = kp_duty - 8'd1;
		kp_wait = interval;
		return 1'b0;
	endfunction

	// Carry out every action that needs no tick until a wait is pending or the keyer is idle.
	function automatic void keyer_run_actions();
		while (kp_wait == 16'd0 && kp_phase != PH_IDLE) begin
			case (kp_phase)
				PH_RAMP_UP: begin
					if (keyer_ramp(cf_high, cf_ramp_up)) begin
						kp_phase = PH_HOLD;
						kp_wait  = kp_dash ? cf_dash : cf_dot;
					end
				end
				PH_HOLD: begin
					kp_key   = 1'b0;
					kp_phase = PH_RAMP_DN;
				end
				PH_RAMP_DN: begin
					if (keyer_ramp(cf_low, cf_ramp_dn)) begin
						kp_phase = PH_GAP;
						kp_wait  = cf_gap;
					end
				end
				PH_GAP: begin
					kp_key   = 1'b1;
					kp_phase = PH_IDLE;
				end
				default: begin
					kp_phase = PH_IDLE;
				end
			endcase
		end
	endfunction

	// Apply one item to the predicted state and return the output it should produce.
	function automatic fmk_result_t keyer_step(input fmk_item_t it);
		fmk_result_t r;
		bit          busy;
		busy = (kp_phase != PH_IDLE);
		r = '0;
		case (it.func)
			FUNC_TICK: begin
				if (busy) begin
					if (kp_wait != 16'd0)
						kp_wait = kp_wait - 16'd1;
					keyer_run_actions();
				end
			end
			FUNC_START: begin
				if (busy) begin
					r.rejected = 1'b1;
				end else if (it.symbol == SYM_DOT || it.symbol == SYM_DASH) begin
					kp_dash  = (it.symbol == SYM_DASH);
					kp_phase = PH_RAMP_UP;
					kp_wait  = 16'd0;
					keyer_run_actions();
				end else if (it.symbol == SYM_PRE) begin
					kp_duty  = cf_low;
					kp_phase = PH_PRE_GAP;
					kp_wait  = cf_gap;
					keyer_run_actions();
				end
			end
			FUNC_KEY: begin
				if (busy)
					r.rejected = 1'b1;
				else
					kp_key = it.key_level;
			end
			default: ;
		endcase
		r.duty     = kp_duty;
		r.key_on   = kp_key;
		r.busy_res = (kp_phase != PH_IDLE);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Item driver: predicts each transfer as it happens and offers the next pending item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				keyer_outputs_due.push_back(keyer_step(item));
			if (!item_valid || !item_stall) begin
				if (item_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					item       <= item_backlog.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each transfer with the oldest prediction and drives the stall.
	always @(posedge clk) begin
		fmk_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (keyer_outputs_due.size() == 0) begin
					report_mismatch("unexpected result duty", result.duty, 8'h00);
				end else begin
					want = keyer_outputs_due.pop_front();
					if (result.duty !== want.duty)
						report_mismatch("duty", result.duty, want.duty);
					if (result.key_on !== want.key_on)
						report_mismatch("key_on", {7'd0, result.key_on},
							{7'd0, want.key_on});
					if (result.busy_res !== want.busy_res)
						report_mismatch("busy_res", {7'd0, result.busy_res},
							{7'd0, want.busy_res});
					if (result.rejected !== want.rejected)
						report_mismatch("rejected", {7'd0, result.rejected},
							{7'd0, want.rejected});
					outputs_matched++;
				end
			end
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Watchdog: ends the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic set_idling(input int mode);
		sender_idle_pct    = (mode == MODE_SENDER) ? 54 : (mode == MODE_BOTH) ? 16 : 0;
		receiver_stall_pct = (mode == MODE_RECEIVER) ? 54 : (mode == MODE_BOTH) ? 16 : 0;
	endtask

	task automatic push_item(input logic [1:0] func, input logic [1:0] sym, input logic lvl);
		fmk_item_t it;
		it.func      = func;
		it.symbol    = sym;
		it.key_level = lvl;
		item_backlog.push_back(it);
		items_queued++;
	endtask

	// Ticks carry random symbol and level bits, which the keyer must ignore.
	task automatic push_tick();
		push_item(FUNC_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
	endtask

	task automatic wait_results();
		while (outputs_matched != items_queued)
			@(posedge clk);
	endtask

	// Feed ticks without idling until the keyer is predicted idle again.
	task automatic settle_keyer();
		int unsigned saved_send, saved_recv, n;
		saved_send = sender_idle_pct;
		saved_recv = receiver_stall_pct;
		set_idling(MODE_NONE);
		wait_results();
		while (kp_phase != PH_IDLE) begin
			n = kp_wait + 1;
			repeat (n) push_tick();
			wait_results();
		end
		sender_idle_pct    = saved_send;
		receiver_stall_pct = saved_recv;
	endtask

	// Register read: setup cycle, then access cycle; the data is taken at the access edge.
	task automatic cfg_read_check(input logic [2:0] idx, input logic [15:0] want);
		logic [31:0] rd;
		logic        rdy;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd  = prdata;
		rdy = pready;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {16'd0, want})
			report_mismatch($sformatf("register %0d read-back", idx), rd[7:0], want[7:0]);
		if (rdy !== 1'b1)
			report_mismatch("pready", {7'd0, rdy}, 8'd1);
	endtask

	// Register write: setup cycle, then access cycle; the register takes the value at its end.
	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
		logic [15:0] want;
		want = (idx == REG_HIGH || idx == REG_LOW) ? {8'd0, value[7:0]} : value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_HIGH:      cf_high    = value[7:0];
			REG_LOW:       cf_low     = value[7:0];
			REG_RAMP_UP:   cf_ramp_up = value;
			REG_RAMP_DN:   cf_ramp_dn = value;
			REG_DOT_HOLD:  cf_dot     = value;
			REG_DASH_HOLD: cf_dash    = value;
			REG_GAP:       cf_gap     = value;
			default: ;
		endcase
		cfg_read_check(idx, want);
	endtask

	task automatic load_settings(input logic [7:0] hi, input logic [7:0] lo,
			input logic [15:0] ru, input logic [15:0] rd, input logic [15:0] dot,
			input logic [15:0] dash, input logic [15:0] gap);
		cfg_write(REG_HIGH, {8'd0, hi});
		cfg_write(REG_LOW, {8'd0, lo});
		cfg_write(REG_RAMP_UP, ru);
		cfg_write(REG_RAMP_DN, rd);
		cfg_write(REG_DOT_HOLD, dot);
		cfg_write(REG_DASH_HOLD, dash);
		cfg_write(REG_GAP, gap);
	endtask

	// Mostly ticks so that symbols run to completion, with commands and spare codes mixed in.
	task automatic push_random_item();
		int unsigned roll;
		logic [1:0]  func, sym;
		roll = $urandom_range(99);
		if (roll < 68)
			func = FUNC_TICK;
		else if (roll < 83)
			func = FUNC_START;
		else if (roll < 95)
			func = FUNC_KEY;
		else
			func = FUNC_NONE;
		sym = ($urandom_range(9) == 0) ? SYM_NONE : 2'($urandom_range(2));
		push_item(func, sym, 1'($urandom_range(1)));
	endtask

	task automatic run_random_phase(input int count, input int mode, input bit long_hold,
			input bit mid_pause);
		set_idling(mode);
		repeat (count / 2) push_random_item();
		if (long_hold)
			hold_req = 1'b1;
		if (mid_pause)
			wait_results();
		repeat (count - count / 2) push_random_item();
		settle_keyer();
	endtask

	// Random settings: levels close together, so that ramps finish within a phase, or wide levels with instant ramps.
	task automatic load_random_settings(input bit wide_levels);
		int lo, hi;
		lo = $urandom_range(255);
		hi = lo + $urandom_range(12) - 6;
		if (hi < 0)
			hi = 0;
		if (hi > 255)
			hi = 255;
		if (wide_levels)
			load_settings(8'($urandom_range(255)), 8'(lo), 16'd0, 16'd0,
				16'($urandom_range(4)), 16'($urandom_range(6)), 16'($urandom_range(4)));
		else
			load_settings(8'(hi), 8'(lo), 16'($urandom_range(3)), 16'($urandom_range(3)),
				16'($urandom_range(4)), 16'($urandom_range(6)), 16'($urandom_range(4)));
	endtask

	initial begin
		cf_high    = HIGH_RESET;
		cf_low     = LOW_RESET;
		cf_ramp_up = RAMP_UP_RESET;
		cf_ramp_dn = RAMP_DN_RESET;
		cf_dot     = DOT_HOLD_RESET;
		cf_dash    = DASH_HOLD_RESET;
		cf_gap     = GAP_RESET;
		kp_phase   = PH_IDLE;
		kp_duty    = DUTY_RESET;
		kp_wait    = 16'd0;
		kp_key     = 1'b0;
		kp_dash    = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Register values after reset.
		cfg_read_check(REG_HIGH, {8'd0, HIGH_RESET});
		cfg_read_check(REG_LOW, {8'd0, LOW_RESET});
		cfg_read_check(REG_RAMP_UP, RAMP_UP_RESET);
		cfg_read_check(REG_RAMP_DN, RAMP_DN_RESET);
		cfg_read_check(REG_DOT_HOLD, DOT_HOLD_RESET);
		cfg_read_check(REG_DASH_HOLD, DASH_HOLD_RESET);
		cfg_read_check(REG_GAP, GAP_RESET);

		// Reset settings: commands while idle and spare codes.
		push_item(FUNC_KEY, SYM_DOT, 1'b1);
		push_item(FUNC_TICK, SYM_DOT, 1'b0);
		push_item(FUNC_NONE, SYM_DASH, 1'b1);
		push_item(FUNC_START, SYM_NONE, 1'b0);
		push_item(FUNC_KEY, SYM_PRE, 1'b0);
		settle_keyer();

		// Short timing from the reset duty: a dot with commands while busy.
		load_settings(8'd140, 8'd120, 16'd2, 16'd1, 16'd4, 16'd6, 16'd3);
		push_item(FUNC_START, SYM_DOT, 1'b0);
		push_item(FUNC_TICK, SYM_DOT, 1'b0);
		push_item(FUNC_START, SYM_DASH, 1'b0);
		push_item(FUNC_KEY, SYM_DOT, 1'b1);
		push_item(FUNC_NONE, SYM_NONE, 1'b1);
		push_item(FUNC_START, SYM_NONE, 1'b1);
		settle_keyer();

		// Zero hold and gap, instant ramp up, slow ramp down from the top; then a pre-letter.
		load_settings(8'd255, 8'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
		push_item(FUNC_START, SYM_DASH, 1'b0);
		push_item(FUNC_TICK, SYM_DOT, 1'b0);
		settle_keyer();
		push_item(FUNC_START, SYM_PRE, 1'b1);
		settle_keyer();

		// Ramps in both directions, one step per tick.
		load_settings(8'd2, 8'd5, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
		push_item(FUNC_START, SYM_DOT, 1'b0);
		repeat (4) push_tick();
		settle_keyer();
		push_item(FUNC_START, SYM_DASH, 1'b0);
		repeat (2) push_tick();
		settle_keyer();

		// Random phases, cycling through the idling modes.
		for (int p = 0; p < 7; p++) begin
			load_random_settings(p % 3 == 2);
			run_random_phase(230, p % 4, p == 1 || p == 5, p == 3);
		end

		// Extreme levels: jumps between the top and bottom duty with a short dot hold.
		load_settings(8'd255, 8'd0, 16'd0, 16'd0, 16'd20, 16'd0, 16'd0);
		run_random_phase(60, MODE_BOTH, 1'b0, 1'b0);
		push_item(FUNC_START, SYM_PRE, 1'b0);
		settle_keyer();

		// Maximal ramp intervals; the duty already sits at both levels, so no step is taken.
		load_settings(8'd0, 8'd0, 16'd65535, 16'd65535, 16'd3, 16'd5, 16'd4);
		run_random_phase(60, MODE_SENDER, 1'b0, 1'b0);

		wait_results();
		repeat (8) @(posedge clk);
		if (keyer_outputs_due.size() != 0)
			report_mismatch("outstanding results", 8'(keyer_outputs_due.size()), 8'd0);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
